// File: rtl/tcst_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcst_pkg - shared types for the touch contact slot tracker
// Request codes, sequencer states and the structs passed between modules.
// ----------------------------------------------------------------------------
package tcst_pkg;

	localparam int ID_W      = 8;
	localparam int POS_W     = 16;
	localparam int SEL_W     = 4;
	localparam int IDX_OUT_W = 4;
	localparam int REQ_W     = 3;

	typedef enum logic [REQ_W-1:0] {
		REQ_DOWN    = 3'd0,
		REQ_MOVE    = 3'd1,
		REQ_UP      = 3'd2,
		REQ_CANCEL  = 3'd3,
		REQ_READ    = 3'd4,
		REQ_CONSUME = 3'd5
	} req_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_APPLY
	} state_t;

	// write controls for the slot store
	typedef struct packed {
		logic             clr_all;
		logic             set_used;
		logic             clr_used;
		logic             wr_pos;
		logic [ID_W-1:0]  contact;
		logic [POS_W-1:0] x;
		logic [POS_W-1:0] y;
	} slot_wr_t;

	// one slot as seen on the read port
	typedef struct packed {
		logic             used;
		logic [ID_W-1:0]  contact;
		logic [POS_W-1:0] x;
		logic [POS_W-1:0] y;
	} slot_rd_t;

	// one result item
	typedef struct packed {
		logic [IDX_OUT_W-1:0] slot_index;
		logic                 slot_hit;
		logic                 slot_active;
		logic [POS_W-1:0]     x;
		logic [POS_W-1:0]     y;
		logic                 latch_value;
	} res_t;

endpackage

// File: rtl/tcst_slot_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcst_slot_store - slot register file
// Active flags, contact ids and positions; one read address, one write address.
// ----------------------------------------------------------------------------
module tcst_slot_store #(
	parameter int SLOT_COUNT = 10,
	parameter int IDX_W      = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [IDX_W-1:0]    rd_addr,
	output tcst_pkg::slot_rd_t  rd,
	input  logic [IDX_W-1:0]    wr_addr,
	input  tcst_pkg::slot_wr_t  wr
);
	import tcst_pkg::*;

	logic             used_q    [SLOT_COUNT];
	logic [ID_W-1:0]  contact_q [SLOT_COUNT];
	logic [POS_W-1:0] x_q       [SLOT_COUNT];
	logic [POS_W-1:0] y_q       [SLOT_COUNT];

	logic rd_ok;
	logic wr_ok;

	assign rd_ok = {1'b0, rd_addr} < (IDX_W+1)'(SLOT_COUNT);
	assign wr_ok = {1'b0, wr_addr} < (IDX_W+1)'(SLOT_COUNT);

	always_comb begin
		rd = '0;
		if (rd_ok) begin
			rd.used    = used_q[rd_addr];
			rd.contact = contact_q[rd_addr];
			rd.x       = x_q[rd_addr];
			rd.y       = y_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOT_COUNT; i++) begin
				used_q[i]    <= 1'b0;
				contact_q[i] <= '0;
				x_q[i]       <= '0;
				y_q[i]       <= '0;
			end
		end else begin
			if (wr.clr_all) begin
				for (int i = 0; i < SLOT_COUNT; i++) begin
					used_q[i] <= 1'b0;
				end
			end else if (wr_ok) begin
				if (wr.set_used) begin
					used_q[wr_addr]    <= 1'b1;
					contact_q[wr_addr] <= wr.contact;
				end else if (wr.clr_used) begin
					used_q[wr_addr] <= 1'b0;
				end
				if (wr.wr_pos) begin
					x_q[wr_addr] <= wr.x;
					y_q[wr_addr] <= wr.y;
				end
			end
		end
	end

endmodule

// File: rtl/tcst_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcst_seq - request sequencer and slot compare unit
// Scans slots one per cycle for a contact match and the lowest free slot.
// ----------------------------------------------------------------------------
module tcst_seq #(
	parameter int SLOT_COUNT = 10,
	parameter int IDX_W      = 4
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [tcst_pkg::REQ_W-1:0]   req_type,
	input  logic [tcst_pkg::ID_W-1:0]    contact_id,
	input  logic [tcst_pkg::POS_W-1:0]   pos_x,
	input  logic [tcst_pkg::POS_W-1:0]   pos_y,
	input  logic [tcst_pkg::SEL_W-1:0]   slot_sel,
	input  logic                         out_free,
	output logic                         res_load,
	output tcst_pkg::res_t               res,
	output logic [IDX_W-1:0]             rd_addr,
	input  tcst_pkg::slot_rd_t           rd,
	output logic [IDX_W-1:0]             wr_addr,
	output tcst_pkg::slot_wr_t           wr
);
	import tcst_pkg::*;

	localparam int CNT_W = $clog2(SLOT_COUNT + 1);

	state_t           state_q, state_d;
	logic [REQ_W-1:0] req_q, req_d;
	logic [ID_W-1:0]  id_q, id_d;
	logic [POS_W-1:0] x_q, x_d;
	logic [POS_W-1:0] y_q, y_d;
	logic [SEL_W-1:0] sel_q, sel_d;
	logic [CNT_W-1:0] scan_q, scan_d;
	logic             mfound_q, mfound_d;
	logic [IDX_W-1:0] midx_q, midx_d;
	logic             ffound_q, ffound_d;
	logic [IDX_W-1:0] fidx_q, fidx_d;
	logic             latch_q, latch_d;

	logic             cmp_hit;
	logic             sel_ok;
	logic             tgt_ok;
	logic [IDX_W-1:0] tgt;

	// shared compare unit
	assign cmp_hit = rd.used && (rd.contact == id_q);
	assign sel_ok  = {1'b0, sel_q} < (SEL_W+1)'(SLOT_COUNT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			req_q    <= '0;
			id_q     <= '0;
			x_q      <= '0;
			y_q      <= '0;
			sel_q    <= '0;
			scan_q   <= '0;
			mfound_q <= 1'b0;
			midx_q   <= '0;
			ffound_q <= 1'b0;
			fidx_q   <= '0;
			latch_q  <= 1'b0;
		end else begin
			state_q  <= state_d;
			req_q    <= req_d;
			id_q     <= id_d;
			x_q      <= x_d;
			y_q      <= y_d;
			sel_q    <= sel_d;
			scan_q   <= scan_d;
			mfound_q <= mfound_d;
			midx_q   <= midx_d;
			ffound_q <= ffound_d;
			fidx_q   <= fidx_d;
			latch_q  <= latch_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		req_d    = req_q;
		id_d     = id_q;
		x_d      = x_q;
		y_d      = y_q;
		sel_d    = sel_q;
		scan_d   = scan_q;
		mfound_d = mfound_q;
		midx_d   = midx_q;
		ffound_d = ffound_q;
		fidx_d   = fidx_q;
		latch_d  = latch_q;
		in_ready = 1'b0;
		res_load = 1'b0;
		res      = '0;
		rd_addr  = sel_q[IDX_W-1:0];
		wr_addr  = '0;
		wr       = '0;
		tgt      = '0;
		tgt_ok   = 1'b0;

		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					req_d    = req_type;
					id_d     = contact_id;
					x_d      = pos_x;
					y_d      = pos_y;
					sel_d    = slot_sel;
					scan_d   = '0;
					mfound_d = 1'b0;
					ffound_d = 1'b0;
					if (req_type == REQ_DOWN || req_type == REQ_MOVE ||
					    req_type == REQ_UP) begin
						state_d = ST_SCAN;
					end else begin
						state_d = ST_APPLY;
					end
				end
			end
			ST_SCAN: begin
				rd_addr = scan_q[IDX_W-1:0];
				if (cmp_hit) begin
					mfound_d = 1'b1;
					midx_d   = scan_q[IDX_W-1:0];
					state_d  = ST_APPLY;
				end else begin
					if (!rd.used && !ffound_q) begin
						ffound_d = 1'b1;
						fidx_d   = scan_q[IDX_W-1:0];
					end
					scan_d = scan_q + CNT_W'(1);
					if (scan_q == CNT_W'(SLOT_COUNT - 1)) begin
						state_d = ST_APPLY;
					end
				end
			end
			ST_APPLY: begin
				// down prefers the matching slot, then the lowest free one
				if (mfound_q) begin
					tgt    = midx_q;
					tgt_ok = 1'b1;
				end else if (ffound_q && req_q == REQ_DOWN) begin
					tgt    = fidx_q;
					tgt_ok = 1'b1;
				end
				wr_addr    = tgt;
				wr.contact = id_q;
				wr.x       = x_q;
				wr.y       = y_q;
				if (out_free) begin
					res_load = 1'b1;
					state_d  = ST_IDLE;
					unique case (req_q)
						REQ_DOWN, REQ_MOVE, REQ_UP: begin
							latch_d = 1'b1;
							if (tgt_ok) begin
								res.slot_index = IDX_OUT_W'(tgt);
								res.slot_hit   = 1'b1;
								wr.set_used    = (req_q == REQ_DOWN);
								wr.wr_pos      = (req_q != REQ_UP);
								wr.clr_used    = (req_q == REQ_UP);
							end
						end
						REQ_CANCEL: begin
							latch_d    = 1'b1;
							wr.clr_all = 1'b1;
						end
						REQ_READ: begin
							if (sel_ok) begin
								res.slot_active = rd.used;
								res.x           = rd.x;
								res.y           = rd.y;
							end
						end
						REQ_CONSUME: begin
							res.latch_value = latch_q;
							latch_d         = 1'b0;
						end
						default: begin
						end
					endcase
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// File: rtl/touch_contact_slot_tracker_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// touch_contact_slot_tracker_top - multitouch contact to slot mapper
// Tracks up to SLOT_COUNT touch contacts: down/move/up/cancel, slot read and
// activity latch consume. One result per request.
// ----------------------------------------------------------------------------
//
// channel  | handshake            | payload
// ---------+----------------------+---------------------------------------------
// in       | in_valid / in_ready  | req_type, contact_id, pos_x, pos_y, slot_sel
// out      | out_valid / out_ready| slot_index, slot_hit, slot_active, out_x,
//          |                      | out_y, latch_value
//
// Down, move and up scan 1..SLOT_COUNT slots through the single contact
// compare unit, one slot per cycle; the scan stops at the first matching
// slot. Other requests skip the scan and go straight from idle to apply.
// Reset (arst_n low) clears all slots to inactive, positions to zero and the
// activity latch; no clearing pass is needed.
// in_ready is high only while the sequencer is idle. A held result in the
// output register does not block acceptance; only the final update stalls
// until the output register is free.
// ----------------------------------------------------------------------------
module touch_contact_slot_tracker_top #(
	parameter int SLOT_COUNT = 10
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [tcst_pkg::REQ_W-1:0]         req_type,
	input  logic [tcst_pkg::ID_W-1:0]          contact_id,
	input  logic signed [tcst_pkg::POS_W-1:0]  pos_x,
	input  logic signed [tcst_pkg::POS_W-1:0]  pos_y,
	input  logic [tcst_pkg::SEL_W-1:0]         slot_sel,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [tcst_pkg::IDX_OUT_W-1:0]     slot_index,
	output logic                               slot_hit,
	output logic                               slot_active,
	output logic signed [tcst_pkg::POS_W-1:0]  out_x,
	output logic signed [tcst_pkg::POS_W-1:0]  out_y,
	output logic                               latch_value
);
	import tcst_pkg::*;

	// slot index width; one bit even for a single slot
	localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

	logic             out_valid_q;
	res_t             res_q;
	res_t             res;
	logic             res_load;
	logic             out_free;
	logic [IDX_W-1:0] rd_addr;
	logic [IDX_W-1:0] wr_addr;
	slot_rd_t         rd;
	slot_wr_t         wr;

	// output register is free when empty or being drained this cycle
	assign out_free = !out_valid_q || out_ready;

	tcst_seq #(
		.SLOT_COUNT (SLOT_COUNT),
		.IDX_W      (IDX_W)
	) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.req_type   (req_type),
		.contact_id (contact_id),
		.pos_x      (pos_x),
		.pos_y      (pos_y),
		.slot_sel   (slot_sel),
		.out_free   (out_free),
		.res_load   (res_load),
		.res        (res),
		.rd_addr    (rd_addr),
		.rd         (rd),
		.wr_addr    (wr_addr),
		.wr         (wr)
	);

	tcst_slot_store #(
		.SLOT_COUNT (SLOT_COUNT),
		.IDX_W      (IDX_W)
	) u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_addr (rd_addr),
		.rd      (rd),
		.wr_addr (wr_addr),
		.wr      (wr)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			res_q       <= '0;
		end else begin
			if (res_load) begin
				out_valid_q <= 1'b1;
				res_q       <= res;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign slot_index  = res_q.slot_index;
	assign slot_hit    = res_q.slot_hit;
	assign slot_active = res_q.slot_active;
	assign out_x       = res_q.x;
	assign out_y       = res_q.y;
	assign latch_value = res_q.latch_value;

`ifndef SYNTHESIS
	// a result only lands in a free output register
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		res_load |-> out_free)
		else $error("result loaded over a pending result");

	// an accepted request keeps the sequencer busy next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("sequencer ready right after accept");

	// a hit always names an existing slot
	a_hit_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && slot_hit) |-> ({1'b0, slot_index} < (IDX_OUT_W+1)'(SLOT_COUNT)))
		else $error("slot hit with index beyond slot count");

	// no result register load while the sequencer is idle
	a_no_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		res_load |-> !in_ready)
		else $error("result loaded while idle");
`endif

endmodule

// File: test/touch_contact_slot_tracker_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench - self-checking bench for touch_contact_slot_tracker_top
// Drives down/move/up/cancel/read/consume requests over the in channel and
// checks every result against a cycle-free model of the slot table kept in a
// small scoreboard. A directed opening covers the corner cases (full table,
// misses, stale position after up, out-of-range read, spare request codes),
// then random gesture-like traffic runs with random idling on both sides, a
// long output stall and a full drain pause.
// ----------------------------------------------------------------------------
module testbench;
	import tcst_pkg::*;

	localparam int SLOTS        = 10;
	localparam int RANDOM_REQS  = 1625;
	localparam int STALL_LIMIT  = 3000;	// cycles with no handshake at all
	localparam int HOLD_CYCLES  = 400;	// long receiver hold-off
	localparam int TAIL_CYCLES  = 40;	// quiet tail after the final drain, to catch stray results
	localparam int POOL_SIZE    = 14;

	// request codes the block ignores
	localparam logic [REQ_W-1:0] REQ_SPARE6 = 3'd6;
	localparam logic [REQ_W-1:0] REQ_SPARE7 = 3'd7;

	// one request as the sender builds it
	typedef struct packed {
		logic [REQ_W-1:0] req_type;
		logic [ID_W-1:0]  contact_id;
		logic [POS_W-1:0] pos_x;
		logic [POS_W-1:0] pos_y;
		logic [SEL_W-1:0] slot_sel;
	} touch_req_s;

	// ------------------------------------------------------------------------
	// Slot table scoreboard: mirrors slot state and the activity latch, turns
	// each accepted request into the result the block must return.
	// ------------------------------------------------------------------------
	class slot_table_scoreboard;
		bit               slot_used[SLOTS];
		logic [ID_W-1:0]  slot_contact[SLOTS];
		logic [POS_W-1:0] slot_x[SLOTS];
		logic [POS_W-1:0] slot_y[SLOTS];
		bit               activity_latch;
		res_t             expected_results[$];
		int               fail_count;
		int               checked_count;
		int               hit_count;
		int               full_table_count;
		int               req_seen[8];

		function new();
			foreach (slot_used[i]) begin
				slot_used[i]    = 1'b0;
				slot_contact[i] = '0;
				slot_x[i]       = '0;
				slot_y[i]       = '0;
			end
			activity_latch = 1'b0;
			fail_count = 0;
			checked_count = 0;
			hit_count = 0;
			full_table_count = 0;
			foreach (req_seen[i])
				req_seen[i] = 0;
		endfunction

		// lowest active slot holding id, SLOTS if none
		function int find_contact(logic [ID_W-1:0] id);
			for (int i = 0; i < SLOTS; i++)
				if (slot_used[i] && slot_contact[i] == id)
					return i;
			return SLOTS;
		endfunction

		function int find_free();
			for (int i = 0; i < SLOTS; i++)
				if (!slot_used[i])
					return i;
			return SLOTS;
		endfunction

		function int results_outstanding();
			return expected_results.size();
		endfunction

		function void note_request(touch_req_s rq);
			res_t r;
			int   s;
			r = '0;
			s = SLOTS;
			unique case (rq.req_type)
				REQ_DOWN: begin
					s = find_contact(rq.contact_id);
					if (s == SLOTS)
						s = find_free();
					if (s < SLOTS) begin
						slot_used[s]    = 1'b1;
						slot_contact[s] = rq.contact_id;
						slot_x[s]       = rq.pos_x;
						slot_y[s]       = rq.pos_y;
					end else begin
						full_table_count++;
					end
					activity_latch = 1'b1;
				end
				REQ_MOVE: begin
					s = find_contact(rq.contact_id);
					if (s < SLOTS) begin
						slot_x[s] = rq.pos_x;
						slot_y[s] = rq.pos_y;
					end
					activity_latch = 1'b1;
				end
				REQ_UP: begin
					s = find_contact(rq.contact_id);
					if (s < SLOTS)
						slot_used[s] = 1'b0;	// contact and position stay
					activity_latch = 1'b1;
				end
				REQ_CANCEL: begin
					foreach (slot_used[i])
						slot_used[i] = 1'b0;
					activity_latch = 1'b1;
				end
				REQ_READ: begin
					if (rq.slot_sel < SLOTS) begin
						r.slot_active = slot_used[rq.slot_sel];
						r.x           = slot_x[rq.slot_sel];
						r.y           = slot_y[rq.slot_sel];
					end
				end
				REQ_CONSUME: begin
					r.latch_value  = activity_latch;
					activity_latch = 1'b0;
				end
				default: ;
			endcase
			if (s < SLOTS) begin
				r.slot_index = IDX_OUT_W'(s);
				r.slot_hit   = 1'b1;
				hit_count++;
			end
			req_seen[rq.req_type]++;
			expected_results.push_back(r);
		endfunction

		function void check_result(res_t got);
			res_t e;
			if (expected_results.size() == 0) begin
				$error("result with no request pending: index %0d hit %0d",
					got.slot_index, got.slot_hit);
				fail_count++;
				return;
			end
			e = expected_results.pop_front();
			checked_count++;
			if (got.slot_index !== e.slot_index) begin
				$error("slot_index: expected %0d, got %0d", e.slot_index, got.slot_index);
				fail_count++;
			end
			if (got.slot_hit !== e.slot_hit) begin
				$error("slot_hit: expected %0d, got %0d", e.slot_hit, got.slot_hit);
				fail_count++;
			end
			if (got.slot_active !== e.slot_active) begin
				$error("slot_active: expected %0d, got %0d", e.slot_active, got.slot_active);
				fail_count++;
			end
			if (got.x !== e.x) begin
				$error("out_x: expected %0d, got %0d", $signed(e.x), $signed(got.x));
				fail_count++;
			end
			if (got.y !== e.y) begin
				$error("out_y: expected %0d, got %0d", $signed(e.y), $signed(got.y));
				fail_count++;
			end
			if (got.latch_value !== e.latch_value) begin
				$error("latch_value: expected %0d, got %0d", e.latch_value, got.latch_value);
				fail_count++;
			end
		endfunction
	endclass

	// ------------------------------------------------------------------------
	// DUT signals; every input has a known value from time zero
	// ------------------------------------------------------------------------
	logic                    clk        = 1'b0;
	logic                    arst_n     = 1'b0;
	logic                    in_valid   = 1'b0;
	logic                    in_ready;
	logic [REQ_W-1:0]        req_type   = '0;
	logic [ID_W-1:0]         contact_id = '0;
	logic signed [POS_W-1:0] pos_x      = '0;
	logic signed [POS_W-1:0] pos_y      = '0;
	logic [SEL_W-1:0]        slot_sel   = '0;
	logic                    out_valid;
	logic                    out_ready  = 1'b0;
	logic [IDX_OUT_W-1:0]    slot_index;
	logic                    slot_hit;
	logic                    slot_active;
	logic signed [POS_W-1:0] out_x;
	logic signed [POS_W-1:0] out_y;
	logic                    latch_value;

	slot_table_scoreboard sb;

	// flags shared between the sender and the receiver
	bit no_idle      = 1'b0;	// both sides run without gaps
	bit hold_request = 1'b0;	// sender asks the receiver for a long hold-off
	int stall_cycles = 0;

	touch_contact_slot_tracker_top #(
		.SLOT_COUNT(SLOTS)
	) u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.req_type   (req_type),
		.contact_id (contact_id),
		.pos_x      (pos_x),
		.pos_y      (pos_y),
		.slot_sel   (slot_sel),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.slot_index (slot_index),
		.slot_hit   (slot_hit),
		.slot_active(slot_active),
		.out_x      (out_x),
		.out_y      (out_y),
		.latch_value(latch_value)
	);

	// 20 ns clock
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// ------------------------------------------------------------------------
	// Monitor: both handshakes are sampled at the rising edge, so the values
	// seen are the pre-edge ones the DUT flops also see. The watchdog counts
	// edges with no handshake on either channel.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		touch_req_s rq;
		res_t       got;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				rq.req_type   = req_type;
				rq.contact_id = contact_id;
				rq.pos_x      = pos_x;
				rq.pos_y      = pos_y;
				rq.slot_sel   = slot_sel;
				sb.note_request(rq);
			end
			if (out_valid && out_ready) begin
				got.slot_index  = slot_index;
				got.slot_hit    = slot_hit;
				got.slot_active = slot_active;
				got.x           = out_x;
				got.y           = out_y;
				got.latch_value = latch_value;
				sb.check_result(got);
			end
			if ((in_valid && in_ready) || (out_valid && out_ready))
				stall_cycles = 0;
			else
				stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("timeout: %0d cycles without a handshake", STALL_LIMIT);
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Receiver: random back-pressure (ready low on about 23 percent of draws), none during the
	// no-idle window, and one long hold-off on request from the sender so the
	// output register fills and in_ready drops while requests keep coming.
	// ------------------------------------------------------------------------
	initial begin
		forever begin
			@(posedge clk);
			if (hold_request) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_request = 1'b0;
				out_ready <= 1'b1;
			end else begin
				out_ready <= no_idle || ($urandom_range(99, 0) >= 23);
			end
		end
	end

	// ------------------------------------------------------------------------
	// Sender tasks
	// ------------------------------------------------------------------------
	function automatic touch_req_s make_req(logic [REQ_W-1:0] kind, logic [ID_W-1:0] id,
		logic [POS_W-1:0] x, logic [POS_W-1:0] y, logic [SEL_W-1:0] sel);
		touch_req_s rq;
		rq.req_type   = kind;
		rq.contact_id = id;
		rq.pos_x      = x;
		rq.pos_y      = y;
		rq.slot_sel   = sel;
		return rq;
	endfunction

	// Present one request and hold it until accepted. Entered and left at a
	// rising edge; valid is only lowered when a gap is taken.
	task automatic send_request(touch_req_s rq);
		int gap;
		gap = 0;
		if (!no_idle && $urandom_range(99, 0) < 23)
			gap = $urandom_range(6, 1);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_type   <= rq.req_type;
		contact_id <= rq.contact_id;
		pos_x      <= rq.pos_x;
		pos_y      <= rq.pos_y;
		slot_sel   <= rq.slot_sel;
		in_valid   <= 1'b1;
		do
			@(posedge clk);
		while (!in_ready);
	endtask

	// Stop offering and wait until every expected result has come back.
	task automatic drain_results();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (sb.results_outstanding() != 0);
	endtask

	// ------------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------------
	initial begin
		logic [ID_W-1:0] id_pool[POOL_SIZE];
		bit              held[256];	// rough sender-side view of live contacts
		logic [ID_W-1:0] id;
		logic [REQ_W-1:0] kind;
		int unsigned     pick;

		sb = new();
		foreach (held[i])
			held[i] = 1'b0;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// --- directed opening ---
		// latch and slot 0 straight out of reset
		send_request(make_req(REQ_CONSUME, 8'h00, 16'h0000, 16'h0000, 4'd0));
		send_request(make_req(REQ_READ, 8'h00, 16'h0000, 16'h0000, 4'd0));
		// fill every slot; first two carry the coordinate extremes
		send_request(make_req(REQ_DOWN, 8'hFF, 16'h7FFF, 16'h8000, 4'hF));
		send_request(make_req(REQ_DOWN, 8'h00, 16'h8000, 16'h7FFF, 4'h0));
		send_request(make_req(REQ_DOWN, 8'h55, 16'h1234, 16'hFEDC, 4'h5));
		send_request(make_req(REQ_DOWN, 8'hAA, 16'hFFFF, 16'h0000, 4'hA));
		send_request(make_req(REQ_DOWN, 8'h0F, 16'h0001, 16'hFFFF, 4'h3));
		send_request(make_req(REQ_DOWN, 8'hF0, 16'h5A5A, 16'hA5A5, 4'hC));
		send_request(make_req(REQ_DOWN, 8'h33, 16'h00FF, 16'hFF00, 4'h1));
		send_request(make_req(REQ_DOWN, 8'hCC, 16'h7F00, 16'h80FF, 4'h8));
		send_request(make_req(REQ_DOWN, 8'h81, 16'h0F0F, 16'hF0F0, 4'h7));
		send_request(make_req(REQ_DOWN, 8'h7E, 16'h3C3C, 16'hC3C3, 4'hE));
		// new contact on a full table is refused
		send_request(make_req(REQ_DOWN, 8'h99, 16'h1111, 16'h2222, 4'h0));
		// repeated down on a live contact updates its slot in place
		send_request(make_req(REQ_DOWN, 8'hAA, 16'h4444, 16'hBBBB, 4'h0));
		send_request(make_req(REQ_MOVE, 8'h0F, 16'h8001, 16'h7FFE, 4'h0));
		send_request(make_req(REQ_MOVE, 8'h99, 16'h6666, 16'h7777, 4'h0));
		send_request(make_req(REQ_UP, 8'h55, 16'h0000, 16'h0000, 4'h0));
		send_request(make_req(REQ_UP, 8'h99, 16'h0000, 16'h0000, 4'h0));
		// released slot still shows its last position, inactive
		send_request(make_req(REQ_READ, 8'h00, 16'h0000, 16'h0000, 4'd2));
		// out-of-range slot reads back zeros
		send_request(make_req(REQ_READ, 8'hFF, 16'hFFFF, 16'hFFFF, 4'd15));
		// spare codes change nothing
		send_request(make_req(REQ_SPARE6, 8'hFF, 16'hFFFF, 16'hFFFF, 4'hF));
		send_request(make_req(REQ_SPARE7, 8'hFF, 16'hFFFF, 16'hFFFF, 4'hF));
		// latch set by the activity above, then clear on the second consume
		send_request(make_req(REQ_CONSUME, 8'h00, 16'h0000, 16'h0000, 4'd0));
		send_request(make_req(REQ_CONSUME, 8'h00, 16'h0000, 16'h0000, 4'd0));
		send_request(make_req(REQ_CANCEL, 8'h00, 16'h0000, 16'h0000, 4'd0));
		send_request(make_req(REQ_READ, 8'h00, 16'h0000, 16'h0000, 4'd0));
		drain_results();

		// --- random traffic ---
		// Mostly gesture-shaped: a small pool of contact IDs goes down, moves
		// and goes up, so the table fills, empties and sees repeat downs.
		// The rest is reads, consumes, cancels, spare codes and stray IDs.
		for (int n = 0; n < RANDOM_REQS; n++) begin
			if (n % 200 == 0)
				foreach (id_pool[i])
					id_pool[i] = ID_W'($urandom_range(255, 0));
			no_idle = (n >= 700 && n < 950);
			if (n == 450)
				drain_results();	// full pause with nothing in flight
			if (n == 1100)
				hold_request = 1'b1;	// receiver stalls, sender keeps offering

			pick = $urandom_range(99, 0);
			id   = id_pool[$urandom_range(POOL_SIZE - 1, 0)];
			if (pick < 8)
				kind = REQ_READ;
			else if (pick < 12)
				kind = REQ_CONSUME;
			else if (pick < 14)
				kind = REQ_CANCEL;
			else if (pick < 16)
				kind = (pick[0]) ? REQ_SPARE7 : REQ_SPARE6;
			else if (pick < 24) begin
				kind = REQ_W'($urandom_range(2, 0));
				id   = ID_W'($urandom_range(255, 0));
			end else if (held[id])
				kind = ($urandom_range(99, 0) < 60) ? REQ_MOVE : REQ_UP;
			else
				kind = REQ_DOWN;

			unique case (kind)
				REQ_DOWN:   held[id] = 1'b1;
				REQ_UP:     held[id] = 1'b0;
				REQ_CANCEL: foreach (held[i]) held[i] = 1'b0;
				default: ;
			endcase

			send_request(make_req(kind, id, POS_W'($urandom), POS_W'($urandom),
				SEL_W'($urandom_range(15, 0))));
		end

		// --- wind down: collect everything, then watch for strays ---
		no_idle = 1'b0;
		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("covered %0d requests: %0d down, %0d move, %0d up, %0d cancel, %0d read,",
			sb.checked_count, sb.req_seen[REQ_DOWN], sb.req_seen[REQ_MOVE],
			sb.req_seen[REQ_UP], sb.req_seen[REQ_CANCEL], sb.req_seen[REQ_READ]);
		$display("%0d consume, %0d spare; %0d slot hits, %0d downs refused on a full table",
			sb.req_seen[REQ_CONSUME], sb.req_seen[REQ_SPARE6] + sb.req_seen[REQ_SPARE7],
			sb.hit_count, sb.full_table_count);
		if (sb.fail_count == 0 && sb.results_outstanding() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

// File: filelist.f
rtl/tcst_pkg.sv
rtl/tcst_slot_store.sv
rtl/tcst_seq.sv
rtl/touch_contact_slot_tracker_top.sv
test/touch_contact_slot_tracker_tb.sv
